[src/wce_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wce_pkg
// shared sizes, register codes, control types and output saturation for the
// windowed covariance estimator
// ----------------------------------------------------------------------------
package wce_pkg;

    localparam int MAX_DATA_ROWS = 64;
    localparam int MAX_DATA_COLS = 64;
    localparam int MAX_WIN_ROWS  = 8;
    localparam int MAX_WIN_COLS  = 8;

    localparam int STORE_DEPTH = MAX_DATA_ROWS * MAX_DATA_COLS;
    localparam int ADDR_W      = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;

    // field widths
    localparam int DIM_W  = 7;
    localparam int WIN_W  = 4;
    localparam int POS_W  = 3;
    localparam int LOAD_W = 6;
    localparam int SMP_W  = 16;
    localparam int WORD_W = 2 * SMP_W;
    localparam int MUL_W  = 2 * SMP_W;
    localparam int PROD_W = MUL_W + 1;
    localparam int OUT_W  = 48;
    localparam int ACC_W  = (PROD_W + ADDR_W + 1 > OUT_W + 1) ? PROD_W + ADDR_W + 1 : OUT_W + 1;

    // configuration port
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    // command codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic signed [ACC_W-1:0] SUM_MAX = {{(ACC_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SUM_MIN = ~SUM_MAX;

    typedef enum logic [1:0] {
        REG_DATA_ROWS,
        REG_DATA_COLS,
        REG_WIN_ROWS,
        REG_WIN_COLS
    } t_reg_idx;

    typedef struct packed {
        logic [DIM_W-1:0] data_rows;
        logic [DIM_W-1:0] data_cols;
        logic [WIN_W-1:0] win_rows;
        logic [WIN_W-1:0] win_cols;
    } t_cfg;

    // one multiply-accumulate request, travels with the store read
    typedef struct packed {
        logic vld;
        logic last;
    } t_mac_ctrl;

    function automatic logic signed [OUT_W-1:0] sat_out(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] t;
        begin
            t = v;
            if (v > SUM_MAX) begin
                t = SUM_MAX;
            end else if (v < SUM_MIN) begin
                t = SUM_MIN;
            end
            return t[OUT_W-1:0];
        end
    endfunction

endpackage
`default_nettype wire

[src/wce_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wce_in_if
// command channel: sample loads and covariance queries
// ----------------------------------------------------------------------------
interface wce_in_if;
    logic                              valid;
    logic                              ready;
    logic                              cmd;
    logic [wce_pkg::LOAD_W-1:0]        data_row;
    logic [wce_pkg::LOAD_W-1:0]        data_col;
    logic signed [wce_pkg::SMP_W-1:0]  sample_re;
    logic signed [wce_pkg::SMP_W-1:0]  sample_im;
    logic [wce_pkg::POS_W-1:0]         first_row;
    logic [wce_pkg::POS_W-1:0]         first_col;
    logic [wce_pkg::POS_W-1:0]         second_row;
    logic [wce_pkg::POS_W-1:0]         second_col;

    modport source (
        output valid, cmd, data_row, data_col, sample_re, sample_im,
               first_row, first_col, second_row, second_col,
        input  ready
    );
    modport sink (
        input  valid, cmd, data_row, data_col, sample_re, sample_im,
               first_row, first_col, second_row, second_col,
        output ready
    );
endinterface
`default_nettype wire

[src/wce_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wce_out_if
// result channel: complex covariance sum and status
// ----------------------------------------------------------------------------
interface wce_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [wce_pkg::OUT_W-1:0]  sum_re;
    logic signed [wce_pkg::OUT_W-1:0]  sum_im;
    logic                              status;

    modport source (output valid, sum_re, sum_im, status, input ready);
    modport sink (input valid, sum_re, sum_im, status, output ready);
endinterface
`default_nettype wire

[src/windowed_covariance_estimator_top.sv]
// a load is written to the store on its transfer; a query walks
// N = (data_rows-win_rows+1)*(data_cols-win_cols+1) window offsets, at most 4096,
// on the single complex multiply-accumulate unit, one window offset per cycle;
// a new command is taken only once the result of the last query is registered
// a rejected query walks no offsets; reset is synchronous, store not cleared
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_covariance_estimator_top
// windowed covariance estimator over a complex sample matrix, with an
// apb-style configuration port and valid/ready command and result channels
// ----------------------------------------------------------------------------
module windowed_covariance_estimator_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [wce_pkg::PADDR_W-1:0]   paddr,
    input  wire logic [wce_pkg::PDATA_W-1:0]   pwdata,
    output logic      [wce_pkg::PDATA_W-1:0]   prdata,
    output logic                               pready,
    // command and result channels
    wce_in_if.sink                             i_in,
    wce_out_if.source                          o_out
);

    // configuration registers
    wce_pkg::t_cfg                    r_cfg;
    wce_pkg::t_reg_idx                w_reg_idx;
    logic                             w_cfg_wr;

    // store write and read paths
    logic                             w_we;
    logic [wce_pkg::ADDR_W-1:0]       w_waddr;
    logic [wce_pkg::WORD_W-1:0]       w_wdata;
    logic [wce_pkg::ADDR_W-1:0]       w_raddr_a, w_raddr_b;
    logic [wce_pkg::WORD_W-1:0]       w_rdata_a, w_rdata_b;

    // mac control and results
    wce_pkg::t_mac_ctrl               w_ctrl;
    logic                             w_clr;
    logic                             w_mac_done;
    logic signed [wce_pkg::ACC_W-1:0] w_acc_re, w_acc_im;

    // register i sits at byte address 4*i, the low two address bits are ignored
    assign pready    = 1'b1;
    assign w_reg_idx = wce_pkg::t_reg_idx'(paddr[wce_pkg::PADDR_W-1:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.data_rows <= wce_pkg::DIM_W'(64);
            r_cfg.data_cols <= wce_pkg::DIM_W'(64);
            r_cfg.win_rows  <= wce_pkg::WIN_W'(8);
            r_cfg.win_cols  <= wce_pkg::WIN_W'(8);
        end else if (w_cfg_wr) begin
            case (w_reg_idx)
                wce_pkg::REG_DATA_ROWS: r_cfg.data_rows <= pwdata[wce_pkg::DIM_W-1:0];
                wce_pkg::REG_DATA_COLS: r_cfg.data_cols <= pwdata[wce_pkg::DIM_W-1:0];
                wce_pkg::REG_WIN_ROWS:  r_cfg.win_rows  <= pwdata[wce_pkg::WIN_W-1:0];
                wce_pkg::REG_WIN_COLS:  r_cfg.win_cols  <= pwdata[wce_pkg::WIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // read-back, zero-extended to the bus width
    always_comb begin
        case (w_reg_idx)
            wce_pkg::REG_DATA_ROWS: prdata = wce_pkg::PDATA_W'(r_cfg.data_rows);
            wce_pkg::REG_DATA_COLS: prdata = wce_pkg::PDATA_W'(r_cfg.data_cols);
            wce_pkg::REG_WIN_ROWS:  prdata = wce_pkg::PDATA_W'(r_cfg.win_rows);
            wce_pkg::REG_WIN_COLS:  prdata = wce_pkg::PDATA_W'(r_cfg.win_cols);
            default:                prdata = '0;
        endcase
    end

    // sequencer: takes commands, walks the window offsets, holds the result
    wce_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in       (i_in),
        .o_out      (o_out),
        .o_we       (w_we),
        .o_waddr    (w_waddr),
        .o_wdata    (w_wdata),
        .o_raddr_a  (w_raddr_a),
        .o_raddr_b  (w_raddr_b),
        .o_ctrl     (w_ctrl),
        .o_clr      (w_clr),
        .i_mac_done (w_mac_done),
        .i_acc_re   (w_acc_re),
        .i_acc_im   (w_acc_im)
    );

    // sample store, both samples of one product read in the same cycle
    wce_sample_ram u_ram (
        .i_clk     (i_clk),
        .i_we      (w_we),
        .i_waddr   (w_waddr),
        .i_wdata   (w_wdata),
        .i_re      (w_ctrl.vld),
        .i_raddr_a (w_raddr_a),
        .i_raddr_b (w_raddr_b),
        .o_rdata_a (w_rdata_a),
        .o_rdata_b (w_rdata_b)
    );

    // shared complex mac, control is delayed inside to meet the read data
    wce_cmac u_cmac (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clr    (w_clr),
        .i_ctrl   (w_ctrl),
        .i_a      (w_rdata_a),
        .i_b      (w_rdata_b),
        .o_done   (w_mac_done),
        .o_acc_re (w_acc_re),
        .o_acc_im (w_acc_im)
    );

    // a rejected query carries a zero sum
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.status) |-> (o_out.sum_re == '0 && o_out.sum_im == '0))
        else $error("rejected query with nonzero sum");

    // the mac only finishes while a query is in progress
    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_mac_done |-> !i_in.ready)
        else $error("mac done while command channel open");

    // offsets are only issued while the command channel is closed
    a_issue_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.vld |-> $past(!i_in.ready))
        else $error("offset issued outside a query");

    // a new result follows a cycle with the command channel closed
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out.valid) |-> $past(!i_in.ready))
        else $error("result without query work");

endmodule
`default_nettype wire

[src/wce_sample_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wce_sample_ram
// sample store, one write port and two registered read ports
// ----------------------------------------------------------------------------
module wce_sample_ram (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [wce_pkg::ADDR_W-1:0]  i_waddr,
    input  wire logic [wce_pkg::WORD_W-1:0]  i_wdata,
    input  wire logic                        i_re,
    input  wire logic [wce_pkg::ADDR_W-1:0]  i_raddr_a,
    input  wire logic [wce_pkg::ADDR_W-1:0]  i_raddr_b,
    output logic      [wce_pkg::WORD_W-1:0]  o_rdata_a,
    output logic      [wce_pkg::WORD_W-1:0]  o_rdata_b
);

    logic [wce_pkg::WORD_W-1:0] r_mem [wce_pkg::STORE_DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            o_rdata_a <= r_mem[i_raddr_a];
            o_rdata_b <= r_mem[i_raddr_b];
        end
    end

endmodule
`default_nettype wire

[src/wce_cmac.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wce_cmac
// shared complex multiply-accumulate unit: multiply, combine, accumulate
// ----------------------------------------------------------------------------
module wce_cmac (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_clr,
    input  wire wce_pkg::t_mac_ctrl                i_ctrl,
    input  wire logic [wce_pkg::WORD_W-1:0]        i_a,
    input  wire logic [wce_pkg::WORD_W-1:0]        i_b,
    output logic                                   o_done,
    output logic signed [wce_pkg::ACC_W-1:0]       o_acc_re,
    output logic signed [wce_pkg::ACC_W-1:0]       o_acc_im
);

    wce_pkg::t_mac_ctrl r_c1, r_c2, r_c3;

    logic signed [wce_pkg::SMP_W-1:0]  w_ar, w_ai, w_br, w_bi;
    logic signed [wce_pkg::MUL_W-1:0]  r_rr, r_ii, r_ri, r_ir;
    logic signed [wce_pkg::PROD_W-1:0] r_s_re, r_s_im;

    // real part in the low half, imaginary part in the high half
    assign w_ar = $signed(i_a[wce_pkg::SMP_W-1:0]);
    assign w_ai = $signed(i_a[wce_pkg::WORD_W-1:wce_pkg::SMP_W]);
    assign w_br = $signed(i_b[wce_pkg::SMP_W-1:0]);
    assign w_bi = $signed(i_b[wce_pkg::WORD_W-1:wce_pkg::SMP_W]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1   <= '0;
            r_c2   <= '0;
            r_c3   <= '0;
            o_done <= 1'b0;
        end else begin
            r_c1   <= i_ctrl;
            r_c2   <= r_c1;
            r_c3   <= r_c2;
            o_done <= r_c3.vld && r_c3.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_c1.vld) begin
            r_rr <= w_ar * w_br;
            r_ii <= w_ai * w_bi;
            r_ri <= w_ar * w_bi;
            r_ir <= w_ai * w_br;
        end
        if (r_c2.vld) begin
            r_s_re <= wce_pkg::PROD_W'(r_rr) - wce_pkg::PROD_W'(r_ii);
            r_s_im <= wce_pkg::PROD_W'(r_ri) + wce_pkg::PROD_W'(r_ir);
        end
        if (i_clr) begin
            o_acc_re <= '0;
            o_acc_im <= '0;
        end else if (r_c3.vld) begin
            o_acc_re <= o_acc_re + wce_pkg::ACC_W'(r_s_re);
            o_acc_im <= o_acc_im + wce_pkg::ACC_W'(r_s_im);
        end
    end

endmodule
`default_nettype wire

[src/wce_seq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// wce_seq
// command sequencer: loads, query checks, window offset walk, result register
// ----------------------------------------------------------------------------
module wce_seq (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire wce_pkg::t_cfg                     i_cfg,
    wce_in_if.sink                                 i_in,
    wce_out_if.source                              o_out,
    output logic                                   o_we,
    output logic [wce_pkg::ADDR_W-1:0]             o_waddr,
    output logic [wce_pkg::WORD_W-1:0]             o_wdata,
    output logic [wce_pkg::ADDR_W-1:0]             o_raddr_a,
    output logic [wce_pkg::ADDR_W-1:0]             o_raddr_b,
    output wce_pkg::t_mac_ctrl                     o_ctrl,
    output logic                                   o_clr,
    input  wire logic                              i_mac_done,
    input  wire logic signed [wce_pkg::ACC_W-1:0]  i_acc_re,
    input  wire logic signed [wce_pkg::ACC_W-1:0]  i_acc_im
);

    typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_DONE} t_state;

    t_state                            r_state;
    logic [wce_pkg::DIM_W-1:0]         r_i, r_j, r_ilim, r_jlim;
    logic [wce_pkg::POS_W-1:0]         r_r1, r_c1, r_r2, r_c2;
    logic signed [wce_pkg::OUT_W-1:0]  r_pend_re, r_pend_im;
    logic                              r_pend_st;
    logic                              r_out_vld;
    logic signed [wce_pkg::OUT_W-1:0]  r_out_re, r_out_im;
    logic                              r_out_st;

    logic                              w_accept, w_err, w_i_end, w_j_end;
    logic [wce_pkg::DIM_W-1:0]         w_row_a, w_col_a, w_row_b, w_col_b;
    logic [wce_pkg::ADDR_W-1:0]        n_addr_a, n_addr_b;

    assign i_in.ready   = (r_state == S_IDLE);
    assign w_accept     = i_in.valid && i_in.ready;
    assign o_out.valid  = r_out_vld;
    assign o_out.sum_re = r_out_re;
    assign o_out.sum_im = r_out_im;
    assign o_out.status = r_out_st;

    // loads go straight to the store
    assign o_we    = w_accept && (i_in.cmd == wce_pkg::OP_LOAD)
                     && (int'(i_in.data_row) < wce_pkg::MAX_DATA_ROWS)
                     && (int'(i_in.data_col) < wce_pkg::MAX_DATA_COLS);
    assign o_waddr = wce_pkg::ADDR_W'(int'(i_in.data_row) * wce_pkg::MAX_DATA_COLS
                                      + int'(i_in.data_col));
    assign o_wdata = {i_in.sample_im, i_in.sample_re};

    always_comb begin
        w_err = (i_cfg.data_rows == '0)
             || (int'(i_cfg.data_rows) > wce_pkg::MAX_DATA_ROWS)
             || (i_cfg.data_cols == '0)
             || (int'(i_cfg.data_cols) > wce_pkg::MAX_DATA_COLS)
             || (i_cfg.win_rows == '0)
             || (int'(i_cfg.win_rows) > wce_pkg::MAX_WIN_ROWS)
             || (i_cfg.win_cols == '0)
             || (int'(i_cfg.win_cols) > wce_pkg::MAX_WIN_COLS)
             || (wce_pkg::DIM_W'(i_cfg.win_rows) > i_cfg.data_rows)
             || (wce_pkg::DIM_W'(i_cfg.win_cols) > i_cfg.data_cols)
             || (wce_pkg::WIN_W'(i_in.first_row) >= i_cfg.win_rows)
             || (wce_pkg::WIN_W'(i_in.second_row) >= i_cfg.win_rows)
             || (wce_pkg::WIN_W'(i_in.first_col) >= i_cfg.win_cols)
             || (wce_pkg::WIN_W'(i_in.second_col) >= i_cfg.win_cols);
    end

    // store addresses of both samples at the current window offset
    always_comb begin
        w_row_a  = r_i + wce_pkg::DIM_W'(r_r1);
        w_col_a  = r_j + wce_pkg::DIM_W'(r_c1);
        w_row_b  = r_i + wce_pkg::DIM_W'(r_r2);
        w_col_b  = r_j + wce_pkg::DIM_W'(r_c2);
        n_addr_a = wce_pkg::ADDR_W'(int'(w_row_a) * wce_pkg::MAX_DATA_COLS + int'(w_col_a));
        n_addr_b = wce_pkg::ADDR_W'(int'(w_row_b) * wce_pkg::MAX_DATA_COLS + int'(w_col_b));
        w_i_end  = (r_i == r_ilim);
        w_j_end  = (r_j == r_jlim);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_out_vld <= 1'b0;
            o_ctrl    <= '0;
            o_clr     <= 1'b0;
        end else begin
            o_ctrl.vld  <= (r_state == S_RUN);
            o_ctrl.last <= (r_state == S_RUN) && w_i_end && w_j_end;
            o_clr       <= w_accept && (i_in.cmd == wce_pkg::OP_QUERY) && !w_err;
            if ((r_state == S_DONE) && (!r_out_vld || o_out.ready)) begin
                r_out_vld <= 1'b1;
            end else if (r_out_vld && o_out.ready) begin
                r_out_vld <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_in.cmd == wce_pkg::OP_QUERY)) begin
                        r_r1   <= i_in.first_row;
                        r_c1   <= i_in.first_col;
                        r_r2   <= i_in.second_row;
                        r_c2   <= i_in.second_col;
                        r_i    <= '0;
                        r_j    <= '0;
                        r_ilim <= i_cfg.data_rows - wce_pkg::DIM_W'(i_cfg.win_rows);
                        r_jlim <= i_cfg.data_cols - wce_pkg::DIM_W'(i_cfg.win_cols);
                        if (w_err) begin
                            r_pend_re <= '0;
                            r_pend_im <= '0;
                            r_pend_st <= 1'b1;
                            r_state   <= S_DONE;
                        end else begin
                            r_pend_st <= 1'b0;
                            r_state   <= S_RUN;
                        end
                    end
                end
                S_RUN: begin
                    o_raddr_a <= n_addr_a;
                    o_raddr_b <= n_addr_b;
                    if (w_j_end) begin
                        r_j <= '0;
                        if (w_i_end) begin
                            r_state <= S_DRAIN;
                        end else begin
                            r_i <= r_i + 1'b1;
                        end
                    end else begin
                        r_j <= r_j + 1'b1;
                    end
                end
                S_DRAIN: begin
                    if (i_mac_done) begin
                        r_pend_re <= wce_pkg::sat_out(i_acc_re);
                        r_pend_im <= wce_pkg::sat_out(i_acc_im);
                        r_state   <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_vld || o_out.ready) begin
                        r_out_re <= r_pend_re;
                        r_out_im <= r_pend_im;
                        r_out_st <= r_pend_st;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

[verif/wce_tb_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wce_tb_pkg
// command codes shared by the stimulus and the result checker of the
// windowed covariance estimator testbench
// ----------------------------------------------------------------------------
package wce_tb_pkg;

    typedef enum logic {
        CMD_LOAD  = wce_pkg::OP_LOAD,
        CMD_QUERY = wce_pkg::OP_QUERY
    } t_cmd;

endpackage

[verif/wce_cov_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wce_cov_checker
// passive checker: follows register writes and sample loads, computes the
// windowed product sum of every query and compares it with each result
// ----------------------------------------------------------------------------
module wce_cov_checker
    import wce_pkg::*;
    import wce_tb_pkg::*;
(
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_psel,
    input  wire logic                i_penable,
    input  wire logic                i_pwrite,
    input  wire logic                i_pready,
    input  wire logic [PADDR_W-1:0]  i_paddr,
    input  wire logic [PDATA_W-1:0]  i_pwdata,
    wce_in_if                        in_mon,
    wce_out_if                       out_mon,
    output int                       o_fail_count,
    output int                       o_pending,
    output int                       o_query_count,
    output int                       o_reject_count
);

    localparam longint OUT_HI      = (64'sd1 <<< (OUT_W - 1)) - 1;
    localparam longint OUT_LO      = -OUT_HI - 1;

    typedef struct packed {
        logic signed [OUT_W-1:0] sum_re;
        logic signed [OUT_W-1:0] sum_im;
        logic                    status;
    } t_cov_result;

    logic [WORD_W-1:0] sample_mem [STORE_DEPTH];
    t_cfg              cfg;
    t_cov_result       expected_sums [$];
    int                fail_count   = 0;
    int                query_count  = 0;
    int                reject_count = 0;

    function automatic logic [OUT_W-1:0] clamp_to_out(input longint v);
        if (v > OUT_HI) begin
            return OUT_HI[OUT_W-1:0];
        end else if (v < OUT_LO) begin
            return OUT_LO[OUT_W-1:0];
        end
        return v[OUT_W-1:0];
    endfunction

    // direct sum over every window offset, plain product without conjugate
    function automatic t_cov_result covariance_of(input t_cfg c,
                                                  input logic [POS_W-1:0] r1, c1, r2, c2);
        t_cov_result       res;
        longint            acc_re, acc_im, ar, ai, br, bi;
        int                nr, nc;
        logic [WORD_W-1:0] a, b;
        res        = '0;
        res.status = 1'b1;
        if (c.data_rows == 0 || c.data_rows > MAX_DATA_ROWS ||
            c.data_cols == 0 || c.data_cols > MAX_DATA_COLS ||
            c.win_rows == 0 || c.win_rows > MAX_WIN_ROWS ||
            c.win_cols == 0 || c.win_cols > MAX_WIN_COLS ||
            c.win_rows > c.data_rows || c.win_cols > c.data_cols ||
            r1 >= c.win_rows || r2 >= c.win_rows ||
            c1 >= c.win_cols || c2 >= c.win_cols) begin
            return res;
        end
        acc_re = 0;
        acc_im = 0;
        nr = int'(c.data_rows) - int'(c.win_rows) + 1;
        nc = int'(c.data_cols) - int'(c.win_cols) + 1;
        for (int i = 0; i < nr; i++) begin
            for (int j = 0; j < nc; j++) begin
                a  = sample_mem[(i + int'(r1)) * MAX_DATA_COLS + j + int'(c1)];
                b  = sample_mem[(i + int'(r2)) * MAX_DATA_COLS + j + int'(c2)];
                ar = longint'($signed(a[SMP_W-1:0]));
                ai = longint'($signed(a[WORD_W-1:SMP_W]));
                br = longint'($signed(b[SMP_W-1:0]));
                bi = longint'($signed(b[WORD_W-1:SMP_W]));
                acc_re += ar * br - ai * bi;
                acc_im += ar * bi + ai * br;
            end
        end
        res.sum_re = clamp_to_out(acc_re);
        res.sum_im = clamp_to_out(acc_im);
        res.status = 1'b0;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_cov_result got;
        t_cov_result want;
        if (!i_rst_n) begin
            cfg = '{data_rows: 7'd64, data_cols: 7'd64, win_rows: 4'd8, win_cols: 4'd8};
            expected_sums.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (t_reg_idx'(i_paddr[PADDR_W-1:2]))
                    REG_DATA_ROWS: cfg.data_rows = i_pwdata[DIM_W-1:0];
                    REG_DATA_COLS: cfg.data_cols = i_pwdata[DIM_W-1:0];
                    REG_WIN_ROWS:  cfg.win_rows  = i_pwdata[WIN_W-1:0];
                    REG_WIN_COLS:  cfg.win_cols  = i_pwdata[WIN_W-1:0];
                    default: ;
                endcase
            end
            if (out_mon.valid && out_mon.ready) begin
                got = '{sum_re: out_mon.sum_re, sum_im: out_mon.sum_im,
                        status: out_mon.status};
                if (expected_sums.size() == 0) begin
                    fail_count++;
                    $display("%0t: expected no result, actual re=%0d im=%0d status=%0d",
                             $time, got.sum_re, got.sum_im, got.status);
                end else begin
                    want = expected_sums.pop_front();
                    if (want.status) reject_count++;
                    if (got != want) begin
                        fail_count++;
                        if (got.sum_re != want.sum_re)
                            $display("%0t: sum_re expected %0d actual %0d",
                                     $time, want.sum_re, got.sum_re);
                        if (got.sum_im != want.sum_im)
                            $display("%0t: sum_im expected %0d actual %0d",
                                     $time, want.sum_im, got.sum_im);
                        if (got.status != want.status)
                            $display("%0t: status expected %0d actual %0d",
                                     $time, want.status, got.status);
                    end
                end
            end
            if (in_mon.valid && in_mon.ready) begin
                if (t_cmd'(in_mon.cmd) == CMD_LOAD) begin
                    sample_mem[int'(in_mon.data_row) * MAX_DATA_COLS + int'(in_mon.data_col)] =
                        {in_mon.sample_im, in_mon.sample_re};
                end else begin
                    query_count++;
                    expected_sums.push_back(covariance_of(cfg, in_mon.first_row,
                        in_mon.first_col, in_mon.second_row, in_mon.second_col));
                end
            end
        end
        o_pending      <= expected_sums.size();
        o_fail_count   <= fail_count;
        o_query_count  <= query_count;
        o_reject_count <= reject_count;
    end

endmodule

[verif/tb_windowed_covariance_estimator_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_windowed_covariance_estimator_top
// drives sample loads, covariance queries and register writes into the
// estimator under random source gaps and sink stalls; the checker beside the
// block predicts every result and this module reports the verdict
// ----------------------------------------------------------------------------
module tb_windowed_covariance_estimator_top;
    import wce_pkg::*;
    import wce_tb_pkg::*;

    // no transfer for this long means the block hung
    localparam int WATCHDOG_LIMIT = 20000;
    // quiet time before a register write
    localparam int SETTLE_CYCLES  = 8;
    // quiet time at the end, after every query is answered
    localparam int DRAIN_CYCLES   = 4110;
    localparam int RANDOM_PHASES  = 3;
    localparam int PHASE_ITEMS    = 12;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    wce_in_if  in_ch ();
    wce_out_if out_ch ();

    int   fail_count;
    int   pending;
    int   query_count;
    int   reject_count;
    int   quiet_cycles = 0;
    int   load_count   = 0;
    int   setting_count = 0;
    // current register setting, mirrors what was last written
    int   cur_dr, cur_dc, cur_wr, cur_wc;
    // store entries loaded since reset; a query never reads an unloaded one
    bit   loaded [STORE_DEPTH];
    // no source gaps and no sink stalls while set
    bit   calm = 1'b0;

    windowed_covariance_estimator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    wce_cov_checker sum_check (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_psel         (psel),
        .i_penable      (penable),
        .i_pwrite       (pwrite),
        .i_pready       (pready),
        .i_paddr        (paddr),
        .i_pwdata       (pwdata),
        .in_mon         (in_ch),
        .out_mon        (out_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_query_count  (query_count),
        .o_reject_count (reject_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // watchdog: any transfer on either channel or the register port rearms it
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // result sink: ready drops at random, in bursts
    initial begin
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (!calm && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
        end
    end

    // sample value biased toward the Q1.15 extremes
    function automatic logic signed [SMP_W-1:0] pick_sample();
        case ($urandom_range(0, 7))
            0:       return 16'sh8000;
            1:       return 16'sh7fff;
            2:       return '0;
            default: return SMP_W'($urandom());
        endcase
    endfunction

    // one register write: setup cycle, then access cycle
    task automatic apb_write(input t_reg_idx idx, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // drop valid, wait for every query to be answered, then settle
    task automatic wait_idle(input int extra);
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (extra) @(posedge i_clk);
    endtask

    // one command transfer, fields that the command does not use carry noise
    task automatic push_command(input t_cmd cmd,
                                input logic [LOAD_W-1:0] row, col,
                                input logic signed [SMP_W-1:0] re, im,
                                input logic [POS_W-1:0] r1, c1, r2, c2);
        int gap;
        gap = 0;
        if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 4);
        if (gap != 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid      <= 1'b1;
        in_ch.cmd        <= cmd;
        in_ch.data_row   <= row;
        in_ch.data_col   <= col;
        in_ch.sample_re  <= re;
        in_ch.sample_im  <= im;
        in_ch.first_row  <= r1;
        in_ch.first_col  <= c1;
        in_ch.second_row <= r2;
        in_ch.second_col <= c2;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (cmd == CMD_LOAD) begin
            loaded[int'(row) * MAX_DATA_COLS + int'(col)] = 1'b1;
            load_count++;
        end
    endtask

    task automatic load_sample(input int row, col,
                               input logic signed [SMP_W-1:0] re, im);
        push_command(CMD_LOAD, LOAD_W'(row), LOAD_W'(col), re, im,
                     POS_W'($urandom()), POS_W'($urandom()),
                     POS_W'($urandom()), POS_W'($urandom()));
    endtask

    task automatic query(input int r1, c1, r2, c2);
        push_command(CMD_QUERY, LOAD_W'($urandom()), LOAD_W'($urandom()),
                     SMP_W'($urandom()), SMP_W'($urandom()),
                     POS_W'(r1), POS_W'(c1), POS_W'(r2), POS_W'(c2));
    endtask

    // every register once, with noise above the register width
    task automatic configure(input int dr, dc, wr, wc);
        wait_idle(SETTLE_CYCLES);
        apb_write(REG_DATA_ROWS, ($urandom() << DIM_W) | PDATA_W'(dr));
        apb_write(REG_DATA_COLS, ($urandom() << DIM_W) | PDATA_W'(dc));
        apb_write(REG_WIN_ROWS,  ($urandom() << WIN_W) | PDATA_W'(wr));
        apb_write(REG_WIN_COLS,  ($urandom() << WIN_W) | PDATA_W'(wc));
        cur_dr = dr;
        cur_dc = dc;
        cur_wr = wr;
        cur_wc = wc;
        setting_count++;
    endtask

    // load every entry of the data area that has not been loaded yet
    task automatic fill_region();
        for (int r = 0; r < cur_dr; r++) begin
            for (int c = 0; c < cur_dc; c++) begin
                if (!loaded[r * MAX_DATA_COLS + c]) load_sample(r, c, pick_sample(), pick_sample());
            end
        end
    endtask

    // a setting that the block must reject, probed with one query
    task automatic reject_probe(input int dr, dc, wr, wc);
        configure(dr, dc, wr, wc);
        query($urandom_range(0, 7), $urandom_range(0, 7),
              $urandom_range(0, 7), $urandom_range(0, 7));
    endtask

    // random setting, then mostly well-formed loads and queries
    task automatic random_phase(input int n_items);
        int dr, dc, wr, wc;
        // short data area, wide enough to reach the last window column
        dr = $urandom_range(1, 4);
        dc = $urandom_range(1, 8);
        if ($urandom_range(0, 4) == 0) begin
            // window may exceed the data, queries then get rejected
            wr = $urandom_range(1, 8);
            wc = $urandom_range(1, 8);
        end else begin
            wr = $urandom_range(1, dr);
            wc = $urandom_range(1, dc);
        end
        configure(dr, dc, wr, wc);
        fill_region();
        repeat (n_items) begin
            if ($urandom_range(0, 9) < 6) begin
                if ($urandom_range(0, 4) == 0) begin
                    query($urandom_range(0, 7), $urandom_range(0, 7),
                          $urandom_range(0, 7), $urandom_range(0, 7));
                end else begin
                    query($urandom_range(0, cur_wr - 1), $urandom_range(0, cur_wc - 1),
                          $urandom_range(0, cur_wr - 1), $urandom_range(0, cur_wc - 1));
                end
            end else if ($urandom_range(0, 3) == 0) begin
                // anywhere in the store, not only the data area
                load_sample($urandom_range(0, 63), $urandom_range(0, 63),
                            pick_sample(), pick_sample());
            end else begin
                load_sample($urandom_range(0, cur_dr - 1), $urandom_range(0, cur_dc - 1),
                            pick_sample(), pick_sample());
            end
        end
    endtask

    initial begin
        i_rst_n          <= 1'b0;
        psel             <= 1'b0;
        penable          <= 1'b0;
        pwrite           <= 1'b0;
        paddr            <= '0;
        pwdata           <= '0;
        in_ch.valid      <= 1'b0;
        in_ch.cmd        <= CMD_LOAD;
        in_ch.data_row   <= '0;
        in_ch.data_col   <= '0;
        in_ch.sample_re  <= '0;
        in_ch.sample_im  <= '0;
        in_ch.first_row  <= '0;
        in_ch.first_col  <= '0;
        in_ch.second_row <= '0;
        in_ch.second_col <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // rejected settings: window larger than data, zero sizes, sizes over the max
        reject_probe(4, 4, 8, 8);
        reject_probe(0, 4, 1, 1);
        reject_probe(100, 4, 1, 1);
        reject_probe(4, 0, 1, 1);
        reject_probe(4, 127, 1, 1);
        reject_probe(4, 4, 0, 1);
        reject_probe(16, 16, 9, 1);
        reject_probe(4, 4, 1, 0);
        reject_probe(16, 16, 1, 15);

        // positions outside the window, then one that fits
        configure(4, 4, 2, 2);
        fill_region();
        query(2, 0, 0, 0);
        query(0, 0, 0, 2);
        query(1, 1, 3, 1);
        query(1, 0, 0, 1);

        // single offset, full-scale samples at the corners
        configure(2, 2, 2, 2);
        fill_region();
        load_sample(0, 0, 16'sh8000, 16'sh8000);
        load_sample(1, 1, 16'sh7fff, 16'sh8000);
        load_sample(0, 1, 16'sh8000, 16'sh7fff);
        load_sample(1, 0, 16'sh7fff, 16'sh7fff);
        query(0, 0, 0, 0);
        query(1, 1, 1, 1);
        query(0, 1, 1, 0);
        query(1, 0, 0, 1);

        // row extreme of the data area, then the smallest setting
        configure(64, 1, 8, 1);
        fill_region();
        query(0, 0, 7, 0);
        query(3, 0, 3, 0);
        configure(1, 1, 1, 1);
        query(0, 0, 0, 0);

        // random part, the last phase with no gaps and no stalls
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            if (p == RANDOM_PHASES - 1) begin
                wait_idle(SETTLE_CYCLES);
                calm = 1'b1;
            end
            random_phase(PHASE_ITEMS);
        end

        wait_idle(DRAIN_CYCLES);
        $display("covered %0d sample loads and %0d queries, %0d of them rejected,",
                 load_count, query_count, reject_count);
        $display("over %0d register settings under random gaps and stalls", setting_count);
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
